[hw/rtl/frp_pkg.sv]
// shared types and constants for the fasta record parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frp_pkg;

	typedef enum logic [2:0] {
		ST_START  = 3'd0,
		ST_END    = 3'd1,
		ST_HDR    = 3'd2,
		ST_HDR_NL = 3'd3,
		ST_SEQ    = 3'd4,
		ST_SEQ_NL = 3'd5
	} parse_state_t;

	typedef enum logic [1:0] {
		K_HDR  = 2'd0,
		K_SEQ  = 2'd1,
		K_REC  = 2'd2,
		K_DROP = 2'd3
	} kind_t;

	localparam logic [7:0] CH_GT = 8'h3e;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_NL = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0d;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_mark(input logic [7:0] c);
		return (c == CH_GT) || (c == CH_SEMI);
	endfunction

endpackage

`default_nettype wire

[hw/rtl/fasta_record_parser.sv]
// fasta record parser top level: input register, parse state and result register
// depends on frp_pkg
`timescale 1ns / 1ps
`default_nettype none

// Parses a FASTA or semicolon-header text stream one byte per item and emits
// header bytes, whitespace-free sequence bytes, record-end and header-discarded
// markers. It takes one item per cycle while the result register is not stalled by
// m_tready: an item is registered, classified against the parse state and lands in
// the result register. A byte of 0, a byte of 128 or above, or s_tlast ends the
// stream with a final record end; later items are accepted and dropped until reset.
// Items that make no result (whitespace, newlines) still pass through the pipeline.
module fasta_record_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [7:0]           s_tdata,   // [7:0] in_byte
	input  wire                  s_tlast,   // end_of_input
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [7:0]           m_tdata,   // [6:0] out_byte, [7] record_valid
	output frp_pkg::kind_t       m_tuser    // [1:0] kind
);
	import frp_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;

	parse_state_t state_q, state_d;
	logic         hdr_seen_q, hdr_seen_d;
	logic         seq_seen_q, seq_seen_d;

	logic         m_valid_q;
	logic [6:0]   out_byte_q;
	logic         rec_valid_q;
	kind_t        kind_q;

	logic         adv;
	logic         end_in;
	logic         res_valid;
	kind_t        res_kind;
	logic [6:0]   res_byte;
	logic         res_rec_valid;

	assign adv      = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign end_in   = last_s1 || (byte_s1 == 8'd0) || byte_s1[7];

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// next state
	always_comb begin
		state_d    = state_q;
		hdr_seen_d = hdr_seen_q;
		seq_seen_d = seq_seen_q;
		if (state_q == ST_END) begin
			state_d = ST_END;
		end else if (end_in) begin
			state_d    = ST_END;
			hdr_seen_d = 1'b0;
			seq_seen_d = 1'b0;
		end else begin
			unique case (state_q)
				ST_START, ST_HDR_NL, ST_SEQ_NL: begin
					if (is_ws(byte_s1)) begin
						state_d = state_q;
					end else if (is_mark(byte_s1)) begin
						state_d    = ST_HDR;
						hdr_seen_d = 1'b0;
						seq_seen_d = 1'b0;
					end else begin
						state_d    = ST_SEQ;
						seq_seen_d = 1'b1;
					end
				end
				ST_HDR: begin
					if (byte_s1 == CH_NL) begin
						state_d = ST_HDR_NL;
					end else begin
						hdr_seen_d = 1'b1;
					end
				end
				ST_SEQ: begin
					if (byte_s1 == CH_NL) begin
						state_d = ST_SEQ_NL;
					end else if (!is_ws(byte_s1)) begin
						seq_seen_d = 1'b1;
					end
				end
				default: begin
					state_d = state_q;
				end
			endcase
		end
	end

	// result
	always_comb begin
		res_valid     = 1'b0;
		res_kind      = K_REC;
		res_byte      = 7'd0;
		res_rec_valid = 1'b0;
		if (state_q == ST_END) begin
			res_valid = 1'b0;
		end else if (end_in) begin
			res_valid     = 1'b1;
			res_kind      = K_REC;
			res_rec_valid = hdr_seen_q && seq_seen_q;
		end else begin
			unique case (state_q)
				ST_START, ST_HDR_NL, ST_SEQ_NL: begin
					if (is_ws(byte_s1)) begin
						res_valid = 1'b0;
					end else if (is_mark(byte_s1)) begin
						if (state_q == ST_HDR_NL) begin
							res_valid = 1'b1;
							res_kind  = K_DROP;
						end else if (state_q == ST_SEQ_NL) begin
							res_valid     = 1'b1;
							res_kind      = K_REC;
							res_rec_valid = 1'b1;
						end
					end else begin
						res_valid = 1'b1;
						res_kind  = K_SEQ;
						res_byte  = byte_s1[6:0];
					end
				end
				ST_HDR: begin
					if (byte_s1 != CH_NL) begin
						res_valid = 1'b1;
						res_kind  = K_HDR;
						res_byte  = byte_s1[6:0];
					end
				end
				ST_SEQ: begin
					if (byte_s1 != CH_NL && !is_ws(byte_s1)) begin
						res_valid = 1'b1;
						res_kind  = K_SEQ;
						res_byte  = byte_s1[6:0];
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	// parse state advances as the registered item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_START;
			hdr_seen_q <= 1'b0;
			seq_seen_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			state_q    <= state_d;
			hdr_seen_q <= hdr_seen_d;
			seq_seen_q <= seq_seen_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q      <= res_kind;
			out_byte_q  <= res_byte;
			rec_valid_q <= res_rec_valid;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {rec_valid_q, out_byte_q};
	assign m_tuser  = kind_q;

	// the end of the stream is sticky until reset
	a_end_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_END |=> state_q == ST_END)
		else $error("parser left the end state");

	// a header byte only comes out of the header state
	a_hdr_from_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && res_valid && res_kind == K_HDR |-> state_q == ST_HDR)
		else $error("header byte outside header state");

	// record_valid is set only on record ends
	a_rec_valid_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_tuser != K_REC |-> !m_tdata[7])
		else $error("record_valid set on a non record-end item");

	// a held input item is not dropped while the result side stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1) && $stable(state_q))
		else $error("input stage changed while stalled");

	// an end-of-input item in a live state always yields a record end
	a_end_gives_rec: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && end_in && state_q != ST_END
		|=> m_valid_q && m_tuser == K_REC && state_q == ST_END)
		else $error("end of input without record end");

endmodule

`default_nettype wire
